### design/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the string edit distance block
// Sizes of the string store and the table values, and the structs that run
// along the row of cells and from the controller to every cell.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int MAX_LEN = 256;
	localparam int SYM_W   = 8;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	// A table value never exceeds MAX_LEN, and the value plus one must still fit.
	localparam int VAL_W   = $clog2(MAX_LEN + 2);
	localparam int DIST_W  = 9;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [DIST_W-1:0] dist_t;

	// What one cell hands to the next cell each cycle: either one column wave
	// (valid) or the result token (fin) that collects the final table value.
	typedef struct packed {
		logic valid;
		logic fin;
		sym_t s;
		sym_t ps;
		logic jgt1;
		logic a_valid;
		sym_t a;
		val_t d;
		val_t dd;
		val_t res;
	} sed_link_t;

	// Broadcast from the controller to all cells.
	typedef struct packed {
		logic init;
		logic wr_en;
		len_t wr_idx;
		sym_t wr_sym;
		logic allow;
		len_t len;
	} sed_bcast_t;

endpackage

### design/sed_in_if.sv
// ----------------------------------------------------------------------------
// sed_in_if: input request channel
// Carries one string byte per request with its string select and marks.
// ----------------------------------------------------------------------------
interface sed_in_if import sed_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	sym_t symbol;
	logic empty_req;
	logic last;

	modport source(output valid, output mode, output symbol, output empty_req,
		output last, input ready);
	modport sink(input valid, input mode, input symbol, input empty_req,
		input last, output ready);
endinterface

### design/sed_out_if.sv
// ----------------------------------------------------------------------------
// sed_out_if: result channel
// Carries the edit distance of one string pair and its overflow flag.
// ----------------------------------------------------------------------------
interface sed_out_if import sed_pkg::*; ();
	logic  valid;
	logic  ready;
	dist_t distance;
	logic  overflow;

	modport source(output valid, output distance, output overflow, input ready);
	modport sink(input valid, input distance, input overflow, output ready);
endinterface

### design/sed_cell.sv
// ----------------------------------------------------------------------------
// sed_cell: one row of the edit distance table
// Holds one byte of the first string and its table entries, computes its
// entry of each new column as the wave passes and forwards it downstream.
// ----------------------------------------------------------------------------
module sed_cell import sed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  len_t       idx,
	input  sed_bcast_t bcast,
	input  sed_link_t  prev_link,
	output sed_link_t  next_link
);

	sym_t a_q;
	val_t d_q;       // own entry of the previous column
	val_t up_q;      // upper neighbor's entry of the previous column
	val_t updiag_q;  // entry two rows up, two columns back
	val_t cost;
	val_t best;
	logic swap;
	sed_link_t link_d;

	always_comb begin
		cost = val_t'(a_q != prev_link.s);
		swap = bcast.allow && prev_link.a_valid && prev_link.jgt1 &&
			(a_q == prev_link.ps) && (prev_link.a == prev_link.s);
		best = d_q + val_t'(1);
		if (prev_link.d + val_t'(1) < best) begin
			best = prev_link.d + val_t'(1);
		end
		if (up_q + cost < best) begin
			best = up_q + cost;
		end
		if (swap && (updiag_q + val_t'(1) < best)) begin
			best = updiag_q + val_t'(1);
		end
	end

	always_comb begin
		link_d         = prev_link;
		link_d.a_valid = 1'b1;
		link_d.a       = a_q;
		link_d.d       = best;
		link_d.dd      = up_q;
		// The token picks up the final entry at the row of the first string's end.
		if (prev_link.fin && (idx + len_t'(1) == bcast.len)) begin
			link_d.res = d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.wr_en && (bcast.wr_idx == idx)) begin
			a_q <= bcast.wr_sym;
		end
		if (bcast.init) begin
			d_q  <= idx + len_t'(1);
			up_q <= val_t'(idx);
		end else if (prev_link.valid) begin
			d_q      <= best;
			up_q     <= prev_link.d;
			updiag_q <= prev_link.dd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_link <= '0;
		end else begin
			next_link <= link_d;
		end
	end

endmodule

### design/sed_ctrl.sv
// ----------------------------------------------------------------------------
// sed_ctrl: request handling and sequencing of the edit distance block
// Loads the first string into the cells, launches one column wave per byte
// of the second string, sends the result token and holds the result.
// ----------------------------------------------------------------------------
module sed_ctrl import sed_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	sed_in_if.sink        item,
	sed_out_if.source     result,
	output sed_link_t     head,
	input  sed_link_t     tail,
	output sed_bcast_t    bcast
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic       allow_q;
	len_t       len_q;
	len_t       jcnt_q;
	sym_t       prev_sym_q;
	logic       loading_q;
	logic       ovf_q;
	sed_link_t  head_q;
	dist_t      dist_q;
	logic       ovf_out_q;

	logic acc;
	logic acc_first;
	logic acc_second;
	logic first_room;
	logic second_room;
	dist_t sat_res;
	sed_link_t head_d;

	assign item.ready  = (state_q == ST_LOAD);
	assign acc         = item.valid && item.ready;
	assign acc_first   = acc && !item.mode && !loading_q;
	assign acc_second  = acc && item.mode && loading_q;
	assign first_room  = (len_q < len_t'(MAX_LEN));
	assign second_room = (jcnt_q < len_t'(MAX_LEN));

	assign bcast.init   = acc_first && item.last;
	assign bcast.wr_en  = acc_first && !item.empty_req && first_room;
	assign bcast.wr_idx = len_q;
	assign bcast.wr_sym = item.symbol;
	assign bcast.allow  = allow_q;
	assign bcast.len    = len_q;

	assign head = head_q;

	always_comb begin
		if ((VAL_W > DIST_W) && (tail.res > val_t'(DIST_MAX))) begin
			sat_res = DIST_MAX;
		end else begin
			sat_res = dist_t'(tail.res);
		end
	end

	always_comb begin
		head_d       = head_q;
		head_d.valid = 1'b0;
		head_d.fin   = 1'b0;
		if (acc_second && !item.empty_req && second_room) begin
			// Row zero of the new column is its column number.
			head_d.valid   = 1'b1;
			head_d.s       = item.symbol;
			head_d.ps      = prev_sym_q;
			head_d.jgt1    = (jcnt_q != '0);
			head_d.a_valid = 1'b0;
			head_d.a       = '0;
			head_d.d       = val_t'(jcnt_q) + val_t'(1);
			head_d.dd      = '0;
			head_d.res     = '0;
		end
		if (state_q == ST_FLUSH) begin
			// An empty first string leaves the column number as the answer.
			head_d.fin = 1'b1;
			head_d.res = val_t'(jcnt_q);
		end
	end

	assign result.valid    = (state_q == ST_OUT);
	assign result.distance = dist_q;
	assign result.overflow = ovf_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b1;
		end else if (cfg_we) begin
			allow_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			len_q      <= '0;
			jcnt_q     <= '0;
			prev_sym_q <= '0;
			loading_q  <= 1'b0;
			ovf_q      <= 1'b0;
			head_q     <= '0;
			dist_q     <= '0;
			ovf_out_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			case (state_q)
				ST_LOAD: begin
					if (acc_first) begin
						if (!item.empty_req) begin
							if (first_room) begin
								len_q <= len_q + len_t'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (item.last) begin
							jcnt_q    <= '0;
							loading_q <= 1'b1;
						end
					end
					if (acc_second) begin
						if (!item.empty_req) begin
							if (second_room) begin
								prev_sym_q <= item.symbol;
								jcnt_q     <= jcnt_q + len_t'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (item.last) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (tail.fin) begin
						dist_q    <= sat_res;
						ovf_out_q <= ovf_q;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						len_q      <= '0;
						jcnt_q     <= '0;
						prev_sym_q <= '0;
						loading_q  <= 1'b0;
						ovf_q      <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_tail_fin_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		tail.fin |-> (state_q == ST_DRAIN))
		else $error("result token left the row outside the drain phase");

	a_token_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		head_q.fin |-> ($past(state_q) == ST_FLUSH))
		else $error("result token launched outside the flush phase");

	a_wave_while_second: assert property (@(posedge clk) disable iff (!arst_n)
		head_q.valid |-> (loading_q && (state_q == ST_LOAD || state_q == ST_FLUSH)))
		else $error("column wave launched while not loading the second string");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready) |=>
		(state_q == ST_LOAD && len_q == '0 && jcnt_q == '0 && !loading_q && !ovf_q))
		else $error("pair state not cleared after the result was taken");

	a_lengths_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= len_t'(MAX_LEN)) && (jcnt_q <= len_t'(MAX_LEN)))
		else $error("string length counter beyond the store size");

endmodule

### design/string_edit_distance.sv
// ----------------------------------------------------------------------------
// string_edit_distance: edit distance between two byte strings
// Restricted Damerau-Levenshtein (optimal string alignment) or plain
// Levenshtein distance, computed by a row of table cells.
// ----------------------------------------------------------------------------
// Each request carries one byte: first all bytes of the first string, then
// all of the second, each ending with a last mark (an empty string is one
// request with empty_req and last). Requests are taken while loading; a
// second-string byte launches a column wave into a row of MAX_LEN cells, one
// cell per first-string byte, so columns follow each other cycle by cycle.
// After the second string's last request, a token walks the whole row and
// picks up the final table entry and the result is captured when it leaves
// the last cell. From that last request until the result is taken, no
// request is accepted. Bytes beyond MAX_LEN are dropped and flagged as
// overflow; distances above 511 read as 511.
// ----------------------------------------------------------------------------
module string_edit_distance import sed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	sed_in_if.sink    item,
	sed_out_if.source result
);

	sed_link_t  links [MAX_LEN+1];
	sed_bcast_t bcast;

	sed_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.result    (result),
		.head      (links[0]),
		.tail      (links[MAX_LEN]),
		.bcast     (bcast)
	);

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		sed_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (len_t'(k)),
			.bcast     (bcast),
			.prev_link (links[k]),
			.next_link (links[k+1])
		);
	end

endmodule
